// ===== rtl/bgtr_pkg.sv =====
package bgtr_pkg;

   localparam int CMD_W     = 2;
   localparam int VADDR_W   = 16;
   localparam int VDATA_W   = 16;
   localparam int PIDX_W    = 8;
   localparam int RGB_W     = 15;
   localparam int MPOS_W    = 6;
   localparam int QUAD_W    = 2;
   localparam int ENTRY_W   = 16;
   localparam int OFFSET_W  = 20;
   localparam int ARGB_W    = 32;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;
   localparam int PITCH_W   = 11;
   localparam int COORD_W   = 10;
   localparam int POS_W     = 6;
   localparam int PIXELS    = 64;

   localparam logic [CMD_W-1:0] CMD_VRAM_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PAL_WRITE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DRAW       = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED     = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_BG_CONTROL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_PITCH  = 1'b1;

   localparam logic [PITCH_W-1:0]   PITCH_RESET = 11'd1024;
   localparam logic [POS_W-1:0]     LAST_POS    = POS_W'(PIXELS - 1);
   localparam logic [7:0]           ALPHA_OPAQUE = 8'hFF;

   typedef struct packed {
      logic             vram_we;
      logic             pal_we;
      logic             start;
      logic             issue;
      logic [POS_W-1:0] pos;
      logic             flush;
   } ctrl_cmd_type;

   typedef struct packed {
      logic draw_ok;
      logic out_free;
      logic pipe_busy;
      logic pend_valid;
   } dp_status_type;

   function automatic logic [ARGB_W-1:0] to_argb(input logic [RGB_W-1:0] c);
      to_argb = {ALPHA_OPAQUE, c[4:0], 3'b000, c[9:5], 3'b000, c[14:10], 3'b000};
   endfunction

endpackage

// ===== rtl/bgtr_ifs.sv =====
interface bgtr_req_if import bgtr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [VADDR_W-1:0]  vram_address;
   logic [VDATA_W-1:0]  vram_data;
   logic [PIDX_W-1:0]   palette_index;
   logic [RGB_W-1:0]    palette_color;
   logic [MPOS_W-1:0]   metatile_x;
   logic [MPOS_W-1:0]   metatile_y;
   logic [QUAD_W-1:0]   quadrant;
   logic [ENTRY_W-1:0]  tile_entry;

   modport source (output valid, command, vram_address, vram_data, palette_index,
                   palette_color, metatile_x, metatile_y, quadrant, tile_entry,
                   input ready);
   modport sink   (input valid, command, vram_address, vram_data, palette_index,
                   palette_color, metatile_x, metatile_y, quadrant, tile_entry,
                   output ready);
endinterface

interface bgtr_rsp_if import bgtr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OFFSET_W-1:0] pixel_offset;
   logic [ARGB_W-1:0]   pixel_color;
   logic                last;

   modport source (output valid, pixel_offset, pixel_color, last, input ready);
   modport sink   (input valid, pixel_offset, pixel_color, last, output ready);
endinterface

interface bgtr_csr_if import bgtr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/bgtr_ctrl.sv =====
module bgtr_ctrl import bgtr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [CMD_W-1:0] req_command,
   output logic             req_ready,
   input  dp_status_type    status,
   output ctrl_cmd_type     cmd
);

   typedef enum logic [1:0] {S_IDLE, S_DRAW, S_FLUSH} state_type;

   state_type        state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      cmd         = '0;
      cmd.pos     = pos_ff;
      req_ready   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_command)
                  CMD_VRAM_WRITE: cmd.vram_we = 1'b1;
                  CMD_PAL_WRITE:  cmd.pal_we  = 1'b1;
                  CMD_DRAW: begin
                     if (status.draw_ok) begin
                        cmd.start = 1'b1;
                        pos_in    = '0;
                        state_in  = S_DRAW;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DRAW: begin
            if (status.out_free) begin
               cmd.issue = 1'b1;
               pos_in    = pos_ff + POS_W'(1);
               if (pos_ff == LAST_POS)
                  state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (!status.pipe_busy) begin
               if (!status.pend_valid) begin
                  state_in = S_IDLE;
               end else if (status.out_free) begin
                  cmd.flush = 1'b1;
                  state_in  = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

// ===== rtl/bgtr_datapath.sv =====
module bgtr_datapath import bgtr_pkg::*; #(
   parameter int VRAM_HALFWORDS = 49152,
   parameter int MAP_WIDE       = 64,
   parameter int MAP_HIGH       = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_cmd_type         cmd,
   output dp_status_type        status,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data,
   input  logic [VADDR_W-1:0]   vram_address,
   input  logic [VDATA_W-1:0]   vram_data,
   input  logic [PIDX_W-1:0]    palette_index,
   input  logic [RGB_W-1:0]     palette_color,
   input  logic [MPOS_W-1:0]    metatile_x,
   input  logic [MPOS_W-1:0]    metatile_y,
   input  logic [QUAD_W-1:0]    quadrant,
   input  logic [ENTRY_W-1:0]   tile_entry,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [OFFSET_W-1:0]  pixel_offset,
   output logic [ARGB_W-1:0]    pixel_color,
   output logic                 last
);

   localparam int VA_W       = $clog2(VRAM_HALFWORDS);
   localparam int BYTE_W     = VA_W + 1;
   localparam int VRAM_BYTES = 2 * VRAM_HALFWORDS;
   localparam int SUM_W      = 18;

   logic [VDATA_W-1:0] vram_mem [VRAM_HALFWORDS];
   logic [RGB_W-1:0]   pal_mem  [256];

   logic [CSR_DAT_W-1:0] bg_control_ff;
   logic [PITCH_W-1:0]   pitch_ff;

   // latched tile entry
   logic [BYTE_W-1:0]  start_ff;
   logic               wide_ff, hflip_ff, vflip_ff;
   logic [3:0]         bank_ff;
   logic [MPOS_W:0]    xq_ff, yq_ff;

   // stage 1
   logic               s1_v_ff;
   logic [VA_W-1:0]    s1_addr_ff;
   logic               s1_bsel_ff, s1_nsel_ff;
   logic [COORD_W-1:0] s1_y_ff, s1_x_ff;
   // stage 2
   logic               s2_v_ff;
   logic [VDATA_W-1:0] vram_q_ff;
   logic               s2_bsel_ff, s2_nsel_ff;
   logic [OFFSET_W-1:0] s2_rowbase_ff;
   logic [COORD_W-1:0] s2_x_ff;
   // stage 3
   logic               s3_v_ff;
   logic [RGB_W-1:0]   pal_q_ff;
   logic [OFFSET_W-1:0] s3_off_ff;
   // pending and output
   logic               pend_v_ff;
   logic [OFFSET_W-1:0] pend_off_ff;
   logic [ARGB_W-1:0]  pend_color_ff;
   logic               out_v_ff;
   logic [OFFSET_W-1:0] out_off_ff;
   logic [ARGB_W-1:0]  out_color_ff;
   logic               out_last_ff;

   logic               adv;
   logic               vram_in_range;
   logic               wide_in;
   logic [15:0]        base_in, tile_off_in;
   logic [SUM_W-1:0]   start_in, end_in;
   logic               on_map;
   logic [2:0]         row, col, sr, sc;
   logic [POS_W-1:0]   tile_byte;
   logic [BYTE_W-1:0]  byte_addr;
   logic [7:0]         byte_val;
   logic [3:0]         nib;
   logic               ci_nz;
   logic [PIDX_W-1:0]  pal_idx;
   logic [COORD_W+PITCH_W-1:0] product;

   assign adv = !out_v_ff || rsp_ready;

   assign vram_in_range = {1'b0, vram_address} < (VADDR_W+1)'(VRAM_HALFWORDS);

   assign wide_in     = bg_control_ff[7];
   assign base_in     = {bg_control_ff[3:2], 14'd0};
   assign tile_off_in = wide_in ? {tile_entry[9:0], 6'd0} : {1'b0, tile_entry[9:0], 5'd0};
   assign start_in    = SUM_W'(base_in) + SUM_W'(tile_off_in);
   assign end_in      = start_in + (wide_in ? SUM_W'(64) : SUM_W'(32));
   assign on_map      = ({1'b0, metatile_x} < (MPOS_W+1)'(MAP_WIDE))
                     && ({1'b0, metatile_y} < (MPOS_W+1)'(MAP_HIGH));

   assign status.draw_ok    = on_map && (end_in <= SUM_W'(VRAM_BYTES));
   assign status.out_free   = adv;
   assign status.pipe_busy  = s1_v_ff || s2_v_ff || s3_v_ff;
   assign status.pend_valid = pend_v_ff;

   assign row       = cmd.pos[5:3];
   assign col       = cmd.pos[2:0];
   assign sr        = vflip_ff ? ~row : row;
   assign sc        = hflip_ff ? ~col : col;
   assign tile_byte = wide_ff ? {sr, sc} : {1'b0, sr, sc[2:1]};
   assign byte_addr = start_ff + BYTE_W'(tile_byte);

   assign byte_val = s2_bsel_ff ? vram_q_ff[15:8] : vram_q_ff[7:0];
   assign nib      = s2_nsel_ff ? byte_val[7:4] : byte_val[3:0];
   assign ci_nz    = wide_ff ? (byte_val != 8'd0) : (nib != 4'd0);
   assign pal_idx  = wide_ff ? byte_val : {bank_ff, nib};

   assign product  = s1_y_ff * pitch_ff;

   always_ff @(posedge clock) begin
      if (cmd.vram_we && vram_in_range)
         vram_mem[vram_address[VA_W-1:0]] <= vram_data;
      if (adv)
         vram_q_ff <= vram_mem[s1_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.pal_we)
         pal_mem[palette_index] <= palette_color;
      if (adv)
         pal_q_ff <= pal_mem[pal_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bg_control_ff <= '0;
         pitch_ff      <= PITCH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BG_CONTROL: bg_control_ff <= csr_data;
            CSR_ROW_PITCH:  pitch_ff      <= csr_data[PITCH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         start_ff <= start_in[BYTE_W-1:0];
         wide_ff  <= wide_in;
         hflip_ff <= tile_entry[10];
         vflip_ff <= tile_entry[11];
         bank_ff  <= tile_entry[15:12];
         xq_ff    <= {metatile_x, quadrant[0]};
         yq_ff    <= {metatile_y, quadrant[1]};
      end
      if (adv) begin
         s1_addr_ff    <= byte_addr[BYTE_W-1:1];
         s1_bsel_ff    <= byte_addr[0];
         s1_nsel_ff    <= sc[0];
         s1_y_ff       <= {yq_ff, row};
         s1_x_ff       <= {xq_ff, col};
         s2_bsel_ff    <= s1_bsel_ff;
         s2_nsel_ff    <= s1_nsel_ff;
         s2_rowbase_ff <= product[OFFSET_W-1:0];
         s2_x_ff       <= s1_x_ff;
         s3_off_ff     <= s2_rowbase_ff + OFFSET_W'(s2_x_ff);
      end
      if (adv && s3_v_ff) begin
         pend_off_ff   <= s3_off_ff;
         pend_color_ff <= to_argb(pal_q_ff);
      end
      if (cmd.flush || (adv && s3_v_ff && pend_v_ff)) begin
         out_off_ff   <= pend_off_ff;
         out_color_ff <= pend_color_ff;
         out_last_ff  <= cmd.flush;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         s3_v_ff   <= 1'b0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         if (adv) begin
            s1_v_ff <= cmd.issue;
            s2_v_ff <= s1_v_ff;
            s3_v_ff <= s2_v_ff && ci_nz;
         end
         if (cmd.flush)
            pend_v_ff <= 1'b0;
         else if (adv && s3_v_ff)
            pend_v_ff <= 1'b1;
         if (cmd.flush)
            out_v_ff <= 1'b1;
         else if (adv)
            out_v_ff <= s3_v_ff && pend_v_ff;
      end
   end

   assign rsp_valid    = out_v_ff;
   assign pixel_offset = out_off_ff;
   assign pixel_color  = out_color_ff;
   assign last         = out_last_ff;

endmodule

// ===== rtl/bg_tile_layer_renderer_core.sv =====
// channel   dir  handshake      payload
// req_bus   in   valid/ready    command, vram/palette write fields, tile draw fields
// rsp_bus   out  valid/ready    pixel_offset, pixel_color, last
// csr_bus   in   valid/ready    index (0 bg_control, 1 row_pitch), data
//
// Write commands do not stall req_bus. A drawn tile that fits keeps req_bus.ready low
// while it issues its 64 pixels and drains the video memory read, palette read and offset
// multiply stages, then, if a pixel is still held, flushes that pixel with last; only
// after that is the next item taken.
// Skipped tiles and unused commands leave the block idle. Reset is synchronous; memory
// contents are not cleared. A low rsp_bus.ready stalls the whole pixel pipeline.
module bg_tile_layer_renderer_core import bgtr_pkg::*; #(
   parameter int VRAM_HALFWORDS = 49152,
   parameter int MAP_WIDE       = 64,
   parameter int MAP_HIGH       = 64
) (
   input  logic           clock,
   input  logic           reset,
   bgtr_req_if.sink       req_bus,
   bgtr_rsp_if.source     rsp_bus,
   bgtr_csr_if.sink       csr_bus
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_bus.ready = 1'b1;

   bgtr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_command (req_bus.command),
      .req_ready   (req_bus.ready),
      .status      (status),
      .cmd         (cmd)
   );

   bgtr_datapath #(
      .VRAM_HALFWORDS (VRAM_HALFWORDS),
      .MAP_WIDE       (MAP_WIDE),
      .MAP_HIGH       (MAP_HIGH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_we        (csr_bus.valid),
      .csr_index     (csr_bus.index),
      .csr_data      (csr_bus.data),
      .vram_address  (req_bus.vram_address),
      .vram_data     (req_bus.vram_data),
      .palette_index (req_bus.palette_index),
      .palette_color (req_bus.palette_color),
      .metatile_x    (req_bus.metatile_x),
      .metatile_y    (req_bus.metatile_y),
      .quadrant      (req_bus.quadrant),
      .tile_entry    (req_bus.tile_entry),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .pixel_offset  (rsp_bus.pixel_offset),
      .pixel_color   (rsp_bus.pixel_color),
      .last          (rsp_bus.last)
   );

endmodule

// ===== rtl/bgtr_checker.sv =====
module bgtr_checker import bgtr_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [CMD_W-1:0]  req_command,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [ARGB_W-1:0] rsp_color,
   input logic              rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   a_write_no_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready
      && (req_command == CMD_VRAM_WRITE || req_command == CMD_PAL_WRITE)
      |=> req_ready)
      else $error("write command blocked the input");

   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("input open before run ended with last");

   a_color_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_color[31:24] == 8'hFF && rsp_color[18:16] == 3'd0
                    && rsp_color[10:8] == 3'd0 && rsp_color[2:0] == 3'd0)
      else $error("malformed pixel color");

endmodule

bind bg_tile_layer_renderer_core bgtr_checker u_bgtr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .req_command (req_bus.command),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_color   (rsp_bus.pixel_color),
   .rsp_last    (rsp_bus.last)
);
